### rtl/stp_pkg.sv
// Shared types, constants and scale decode for the signature template parser.
// No dependencies.
package stp_pkg;

    typedef enum logic [3:0] {
        PH_SEARCH = 4'd0,
        PH_TAG    = 4'd1,
        PH_XSCALE = 4'd2,
        PH_SKIPXY = 4'd3,
        PH_YSCALE = 4'd4,
        PH_TSCALE = 4'd5,
        PH_MINF   = 4'd6,
        PH_MAXF   = 4'd7,
        PH_SKIP3  = 4'd8,
        PH_LEN    = 4'd9,
        PH_TRIPLE = 4'd10
    } t_phase;

    typedef enum logic {
        CTL_IDLE = 1'b0,
        CTL_DIV  = 1'b1
    } t_ctl;

    localparam logic [3:0] KIND_HEADER = 4'd0;
    localparam logic [3:0] KIND_XSCALE = 4'd1;
    localparam logic [3:0] KIND_YSCALE = 4'd2;
    localparam logic [3:0] KIND_TSCALE = 4'd3;
    localparam logic [3:0] KIND_MINF   = 4'd4;
    localparam logic [3:0] KIND_MAXF   = 4'd5;
    localparam logic [3:0] KIND_LEN    = 4'd6;
    localparam logic [3:0] KIND_X      = 4'd7;
    localparam logic [3:0] KIND_Y      = 4'd8;
    localparam logic [3:0] KIND_FORCE  = 4'd9;

    localparam logic [7:0]  TAG_XY    = 8'h80;
    localparam logic [7:0]  TAG_TIME  = 8'h84;
    localparam logic [7:0]  TAG_FORCE = 8'h60;
    localparam logic [23:0] SDI_SEQ   = 24'h534449;

    localparam int          DIV_BITS    = 10;
    localparam logic [9:0]  DIV_NUMER   = 10'd1000;
    localparam logic [3:0]  DIV_STEPS   = 4'd10;

    localparam logic [1:0]  SLOT_X = 2'd0;
    localparam logic [1:0]  SLOT_Y = 2'd1;
    localparam logic [1:0]  SLOT_F = 2'd2;

    // floor((2048+F) * 2^E / 2^27): shift left by E, keep bits 42..27.
    function automatic logic [15:0] scale_value(input logic [15:0] word);
        logic [42:0] wide;
        wide = 43'({1'b1, word[10:0]}) << word[15:11];
        return wide[42:27];
    endfunction

endpackage

### rtl/signature_template_parser.sv
// Signature template parser top level: byte parser, scale decode and
// serial divider for the sample interval. Depends on stp_pkg.
//
// Takes one template byte per word on the input channel and gives at most
// one decoded item per byte. The parser hunts for the byte sequence "SDI",
// then reads tags: 0x80 (X scale, skip byte, Y scale), 0x84 (time scale),
// 0x60 (min force, max force, three skipped bytes, record length, then
// endless x/y/force triples). Words are big-endian. Scale words are decoded
// to floor((1+F/2048)*2^(E-16)). Throughput is one byte per cycle while
// the output is not stalled, except that the byte completing a time-scale
// word starts a restoring divider that forms 1000/scale one quotient bit
// per cycle; the input stalls until it ends (none if the scale is zero). A
// restart bit on a byte resets every parser register, the sample interval
// included, before that byte is parsed. Results sit in an output register;
// with the divider idle, a new byte is taken in the cycle the result drains.
module signature_template_parser
    import stp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_restart,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_item_kind,
    output logic [15:0] o_item_value,
    output logic [9:0]  o_sample_time
);

    // parser state
    t_phase      r_phase,   n_phase;
    logic [2:0]  r_pos,     n_pos;
    logic [7:0]  r_high,    n_high;
    logic [15:0] r_hist,    n_hist;
    logic [9:0]  r_intv,    n_intv;
    logic        r_first,   n_first;
    logic [1:0]  r_slot,    n_slot;

    // divider
    t_ctl        r_ctl,     n_ctl;
    logic [15:0] r_dvsr,    n_dvsr;
    logic [15:0] r_rem,     n_rem;
    logic [9:0]  r_quo,     n_quo;
    logic [3:0]  r_cnt,     n_cnt;

    // output register
    logic        r_out_vld;
    logic [3:0]  r_kind;
    logic [15:0] r_value;
    logic [9:0]  r_time;

    logic        in_acc;
    logic        emit;
    logic [3:0]  e_kind;
    logic [15:0] e_value;
    logic [9:0]  e_time;

    // effective state after an optional restart
    t_phase      c_phase;
    logic [2:0]  c_pos;
    logic [7:0]  c_high;
    logic [15:0] c_hist;
    logic [9:0]  c_intv;
    logic        c_first;
    logic [1:0]  c_slot;
    logic [23:0] seq;
    logic [15:0] word;
    logic [15:0] scale;
    logic        start_div;

    logic [16:0] trial;
    logic        q_bit;

    assign o_in_stall = (r_ctl != CTL_IDLE) || (r_out_vld && i_out_stall);
    assign in_acc     = i_in_valid && !o_in_stall;

    assign c_phase = i_restart ? PH_SEARCH : r_phase;
    assign c_pos   = i_restart ? 3'd0      : r_pos;
    assign c_high  = i_restart ? 8'd0      : r_high;
    assign c_hist  = i_restart ? 16'd0     : r_hist;
    assign c_intv  = i_restart ? 10'd0     : r_intv;
    assign c_first = i_restart ? 1'b1      : r_first;
    assign c_slot  = i_restart ? SLOT_X    : r_slot;

    assign seq   = {c_hist, i_data_byte};
    assign word  = {c_high, i_data_byte};
    assign scale = scale_value(word);

    // next parser state
    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_high    = r_high;
        n_hist    = r_hist;
        n_intv    = r_intv;
        n_first   = r_first;
        n_slot    = r_slot;
        start_div = 1'b0;
        if (in_acc) begin
            n_phase = c_phase;
            n_pos   = c_pos;
            n_high  = c_high;
            n_hist  = c_hist;
            n_intv  = c_intv;
            n_first = c_first;
            n_slot  = c_slot;
            case (c_phase)
                PH_SEARCH: begin
                    n_hist = seq[15:0];
                    if (seq == SDI_SEQ) begin
                        n_phase = PH_TAG;
                        n_pos   = 3'd0;
                    end
                end
                PH_TAG: begin
                    n_pos = 3'd0;
                    if (i_data_byte == TAG_XY) begin
                        n_phase = PH_XSCALE;
                    end else if (i_data_byte == TAG_TIME) begin
                        n_phase = PH_TSCALE;
                    end else if (i_data_byte == TAG_FORCE) begin
                        n_phase = PH_MINF;
                        n_first = 1'b1;
                    end
                end
                PH_SKIPXY: begin
                    n_phase = PH_YSCALE;
                    n_pos   = 3'd0;
                end
                PH_SKIP3: begin
                    if (c_pos >= 3'd2) begin
                        n_phase = PH_LEN;
                        n_pos   = 3'd0;
                    end else begin
                        n_pos = c_pos + 3'd1;
                    end
                end
                PH_XSCALE, PH_YSCALE, PH_TSCALE, PH_MINF, PH_MAXF, PH_LEN,
                PH_TRIPLE: begin
                    if (c_pos == 3'd0) begin
                        n_high = i_data_byte;
                        n_pos  = 3'd1;
                    end else begin
                        n_pos = 3'd0;
                        case (c_phase)
                            PH_XSCALE: n_phase = PH_SKIPXY;
                            PH_YSCALE: n_phase = PH_TAG;
                            PH_TSCALE: begin
                                n_phase   = PH_TAG;
                                n_intv    = 10'd0;
                                start_div = (scale != 16'd0);
                            end
                            PH_MINF:   n_phase = PH_MAXF;
                            PH_MAXF:   n_phase = PH_SKIP3;
                            PH_LEN: begin
                                n_phase = PH_TRIPLE;
                                n_slot  = SLOT_X;
                            end
                            PH_TRIPLE: begin
                                if (c_slot == SLOT_X) begin
                                    n_first = 1'b0;
                                    n_slot  = SLOT_Y;
                                end else if (c_slot == SLOT_Y) begin
                                    n_slot = SLOT_F;
                                end else begin
                                    n_slot = SLOT_X;
                                end
                            end
                            default: n_phase = PH_SEARCH;
                        endcase
                    end
                end
                default: begin
                    n_phase = PH_SEARCH;
                    n_hist  = 16'd0;
                end
            endcase
        end
        // divider finishing writes the interval; input is stalled then
        if (r_ctl == CTL_DIV && r_cnt == 4'd1) begin
            n_intv = n_quo;
        end
    end

    // item produced by the accepted byte
    always_comb begin
        emit    = 1'b0;
        e_kind  = KIND_HEADER;
        e_value = 16'd0;
        e_time  = 10'd0;
        case (c_phase)
            PH_SEARCH: emit = (seq == SDI_SEQ);
            PH_XSCALE, PH_YSCALE, PH_TSCALE, PH_MINF, PH_MAXF, PH_LEN,
            PH_TRIPLE: begin
                emit    = (c_pos != 3'd0);
                e_value = word;
                case (c_phase)
                    PH_XSCALE: begin
                        e_kind  = KIND_XSCALE;
                        e_value = scale;
                    end
                    PH_YSCALE: begin
                        e_kind  = KIND_YSCALE;
                        e_value = scale;
                    end
                    PH_TSCALE: begin
                        e_kind  = KIND_TSCALE;
                        e_value = scale;
                    end
                    PH_MINF:   e_kind = KIND_MINF;
                    PH_MAXF:   e_kind = KIND_MAXF;
                    PH_LEN:    e_kind = KIND_LEN;
                    default: begin
                        if (c_slot == SLOT_X) begin
                            e_kind = KIND_X;
                            e_time = c_first ? 10'd0 : c_intv;
                        end else if (c_slot == SLOT_Y) begin
                            e_kind = KIND_Y;
                        end else begin
                            e_kind = KIND_FORCE;
                        end
                    end
                endcase
            end
            default: emit = 1'b0;
        endcase
    end

    // restoring divider: one quotient bit of 1000/scale per cycle
    assign trial = {r_rem, DIV_NUMER[r_cnt - 4'd1]};
    assign q_bit = (trial >= {1'b0, r_dvsr});

    always_comb begin
        n_ctl  = r_ctl;
        n_dvsr = r_dvsr;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        case (r_ctl)
            CTL_IDLE: begin
                if (start_div) begin
                    n_ctl  = CTL_DIV;
                    n_dvsr = scale;
                    n_rem  = 16'd0;
                    n_quo  = 10'd0;
                    n_cnt  = DIV_STEPS;
                end
            end
            CTL_DIV: begin
                n_rem = q_bit ? 16'(trial - {1'b0, r_dvsr}) : trial[15:0];
                n_quo = {r_quo[DIV_BITS-2:0], q_bit};
                n_cnt = r_cnt - 4'd1;
                if (r_cnt == 4'd1) begin
                    n_ctl = CTL_IDLE;
                end
            end
            default: n_ctl = CTL_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SEARCH;
            r_pos     <= 3'd0;
            r_high    <= 8'd0;
            r_hist    <= 16'd0;
            r_intv    <= 10'd0;
            r_first   <= 1'b1;
            r_slot    <= SLOT_X;
            r_ctl     <= CTL_IDLE;
            r_cnt     <= 4'd0;
            r_out_vld <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_high  <= n_high;
            r_hist  <= n_hist;
            r_intv  <= n_intv;
            r_first <= n_first;
            r_slot  <= n_slot;
            r_ctl   <= n_ctl;
            r_cnt   <= n_cnt;
            if (in_acc && emit) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvsr <= n_dvsr;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        if (in_acc && emit) begin
            r_kind  <= e_kind;
            r_value <= e_value;
            r_time  <= e_time;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_item_kind   = r_kind;
    assign o_item_value  = r_value;
    assign o_sample_time = r_time;

endmodule

### rtl/stp_chk.sv
// Port-level checker for the signature template parser, bound to the top.
// Depends on stp_pkg.
module stp_chk
    import stp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [3:0]  o_item_kind,
    input logic [15:0] o_item_value,
    input logic [9:0]  o_sample_time
);

    // held word keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_item_kind)
            && $stable(o_item_value) && $stable(o_sample_time))
        else $error("output word changed while stalled");

    // a blocked result must block the input
    a_backpress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("input open while output word blocked");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_item_kind <= KIND_FORCE)
        else $error("item kind out of range");

    a_time_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_item_kind != KIND_X |-> o_sample_time == 10'd0)
        else $error("sample time on non-x item");

    a_header_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_item_kind == KIND_HEADER |-> o_item_value == 16'd0)
        else $error("header item carries a value");

endmodule

bind signature_template_parser stp_chk u_stp_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_item_kind   (o_item_kind),
    .o_item_value  (o_item_value),
    .o_sample_time (o_sample_time)
);
